// ===== hdl/rrts_pkg.sv =====
// shared types, codes and sizes for the round-robin task scheduler
package rrts_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int ID_W      = 4;
  localparam int PRIO_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int REQ_W     = 3;
  localparam int CODE_W    = 2;

  localparam logic [PRIO_W-1:0] KERNEL_PRIORITY = PRIO_W'(31);

  // request types
  localparam logic [REQ_W-1:0] REQ_CREATE   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_CANCEL   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_SCHEDULE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SWITCH   = 3'd3;
  localparam logic [REQ_W-1:0] REQ_BLOCK    = 3'd4;
  localparam logic [REQ_W-1:0] REQ_UNBLOCK  = 3'd5;

  // result codes
  localparam logic [CODE_W-1:0] RES_OK      = 2'd0;
  localparam logic [CODE_W-1:0] RES_SLOT    = 2'd1;
  localparam logic [CODE_W-1:0] RES_RUNNING = 2'd2;
  localparam logic [CODE_W-1:0] RES_QUEUED  = 2'd3;

  // task status codes
  localparam logic [STATUS_W-1:0] ST_RUNNING = 3'd0;
  localparam logic [STATUS_W-1:0] ST_READY   = 3'd1;

  typedef logic [SLOT_W-1:0] slot_t;

  typedef enum logic [1:0] {
    Q_NONE,
    Q_REMOVE,
    Q_PUSH_HEAD,
    Q_PUSH_TAIL
  } q_op_e;

  typedef struct packed {
    q_op_e op;
    slot_t id;
  } q_cmd_t;

  typedef struct packed {
    logic  occ;
    slot_t id;
  } q_entry_t;

  typedef struct packed {
    logic  empty;
    logic  full;
    logic  found;
    slot_t head;
  } q_stat_t;

  typedef struct packed {
    logic                val_set;
    logic                val_clr;
    logic                st_we;
    logic [STATUS_W-1:0] status;
    logic                pr_we;
    logic [PRIO_W-1:0]   prio;
    logic                tk_we;
    logic [PRIO_W-1:0]   ticks;
    slot_t               addr;
  } slot_wr_t;

  typedef struct packed {
    logic  en;
    slot_t addr;
  } slot_rd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [PRIO_W-1:0]   prio;
    logic [PRIO_W-1:0]   ticks;
  } slot_data_t;

endpackage

// ===== hdl/rrts_queue_cell.sv =====
// one position of the ready queue, shifting toward head or tail with its neighbors
module rrts_queue_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rrts_pkg::q_cmd_t   cmd_i,
  input  rrts_pkg::q_entry_t left_i,
  input  logic              left_hit_i,
  input  rrts_pkg::q_entry_t right_i,
  output rrts_pkg::q_entry_t ent_o,
  output logic              hit_o
);

  rrts_pkg::q_entry_t ent_q, ent_d;
  logic               match;

  assign match = ent_q.occ && (ent_q.id == cmd_i.id);
  // a match here or anywhere toward the head
  assign hit_o = left_hit_i | match;
  assign ent_o = ent_q;

  always_comb begin
    ent_d = ent_q;
    unique case (cmd_i.op)
      rrts_pkg::Q_NONE: begin
      end
      rrts_pkg::Q_REMOVE: begin
        if (hit_o) begin
          ent_d = right_i;
        end
      end
      rrts_pkg::Q_PUSH_HEAD: begin
        ent_d = left_i;
      end
      rrts_pkg::Q_PUSH_TAIL: begin
        // first free position takes the new item
        if (!ent_q.occ && left_i.occ) begin
          ent_d.occ = 1'b1;
          ent_d.id  = cmd_i.id;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

endmodule

// ===== hdl/rrts_ready_queue.sv =====
// ready queue built as a row of cells, head at cell zero
module rrts_ready_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rrts_pkg::q_cmd_t  cmd_i,
  output rrts_pkg::q_stat_t stat_o
);

  rrts_pkg::q_entry_t             ent   [rrts_pkg::NUM_SLOTS];
  rrts_pkg::q_entry_t             left  [rrts_pkg::NUM_SLOTS];
  rrts_pkg::q_entry_t             right [rrts_pkg::NUM_SLOTS];
  logic [rrts_pkg::NUM_SLOTS-1:0] hit;
  logic [rrts_pkg::NUM_SLOTS-1:0] left_hit;

  for (genvar i = 0; i < rrts_pkg::NUM_SLOTS; i++) begin : g_cell
    if (i == 0) begin : g_head
      // head sees the new id as an occupied left neighbor
      assign left[i].occ = 1'b1;
      assign left[i].id  = cmd_i.id;
      assign left_hit[i] = 1'b0;
    end else begin : g_mid
      assign left[i]     = ent[i-1];
      assign left_hit[i] = hit[i-1];
    end
    if (i == rrts_pkg::NUM_SLOTS - 1) begin : g_tail
      assign right[i] = '0;
    end else begin : g_inner
      assign right[i] = ent[i+1];
    end

    rrts_queue_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd_i),
      .left_i     (left[i]),
      .left_hit_i (left_hit[i]),
      .right_i    (right[i]),
      .ent_o      (ent[i]),
      .hit_o      (hit[i])
    );
  end

  assign stat_o.empty = !ent[0].occ;
  assign stat_o.full  = ent[rrts_pkg::NUM_SLOTS-1].occ;
  assign stat_o.found = hit[rrts_pkg::NUM_SLOTS-1];
  assign stat_o.head  = ent[0].id;

endmodule

// ===== hdl/rrts_slot_table.sv =====
// per-slot valid bits and status, priority and slice memories
module rrts_slot_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  rrts_pkg::slot_wr_t              wr_i,
  input  rrts_pkg::slot_rd_t              rd_i,
  output rrts_pkg::slot_data_t            rd_data_o,
  output logic [rrts_pkg::NUM_SLOTS-1:0] valid_o
);

  logic [rrts_pkg::NUM_SLOTS-1:0] valid_q;
  logic [rrts_pkg::NUM_SLOTS-1:0] st_wr_q, pr_wr_q, tk_wr_q;

  logic [rrts_pkg::STATUS_W-1:0] st_mem [rrts_pkg::NUM_SLOTS];
  logic [rrts_pkg::PRIO_W-1:0]   pr_mem [rrts_pkg::NUM_SLOTS];
  logic [rrts_pkg::PRIO_W-1:0]   tk_mem [rrts_pkg::NUM_SLOTS];

  logic [rrts_pkg::STATUS_W-1:0] st_rd_q;
  logic [rrts_pkg::PRIO_W-1:0]   pr_rd_q, tk_rd_q;
  logic                          st_ok_q, pr_ok_q, tk_ok_q, first_q;
  logic [rrts_pkg::PRIO_W-1:0]   rst_val;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= rrts_pkg::NUM_SLOTS'(1);
      st_wr_q <= '0;
      pr_wr_q <= '0;
      tk_wr_q <= '0;
    end else begin
      if (wr_i.val_set) begin
        valid_q[wr_i.addr] <= 1'b1;
      end else if (wr_i.val_clr) begin
        valid_q[wr_i.addr] <= 1'b0;
      end
      if (wr_i.st_we) begin
        st_wr_q[wr_i.addr] <= 1'b1;
      end
      if (wr_i.pr_we) begin
        pr_wr_q[wr_i.addr] <= 1'b1;
      end
      if (wr_i.tk_we) begin
        tk_wr_q[wr_i.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.st_we) begin
      st_mem[wr_i.addr] <= wr_i.status;
    end
    if (wr_i.pr_we) begin
      pr_mem[wr_i.addr] <= wr_i.prio;
    end
    if (wr_i.tk_we) begin
      tk_mem[wr_i.addr] <= wr_i.ticks;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      st_rd_q <= st_mem[rd_i.addr];
      pr_rd_q <= pr_mem[rd_i.addr];
      tk_rd_q <= tk_mem[rd_i.addr];
      st_ok_q <= st_wr_q[rd_i.addr];
      pr_ok_q <= pr_wr_q[rd_i.addr];
      tk_ok_q <= tk_wr_q[rd_i.addr];
      first_q <= (rd_i.addr == '0);
    end
  end

  // unwritten entries read as their reset value, slot zero starts at kernel priority
  assign rst_val = first_q ? rrts_pkg::KERNEL_PRIORITY : '0;

  assign rd_data_o.status = st_ok_q ? st_rd_q : '0;
  assign rd_data_o.prio   = pr_ok_q ? pr_rd_q : rst_val;
  assign rd_data_o.ticks  = tk_ok_q ? tk_rd_q : rst_val;
  assign valid_o          = valid_q;

endmodule

// ===== hdl/round_robin_task_scheduler.sv =====
// the path from item accept to result valid depends on request type
// (block takes longest: status write, schedule, queue rotate, pick, switch, slice read)
// one item at a time: in_stall_o is high until the sequencer is back in idle; the slot memory
// read port and the queue cell row each take one operation per cycle
// reset: task 0 valid and running with priority 31, queue empty, no clearing pass
// top level: request sequencer over the slot table and the ready queue cell row
module round_robin_task_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rrts_pkg::REQ_W-1:0]    req_type_i,
  input  logic [rrts_pkg::ID_W-1:0]     task_id_i,
  input  logic [rrts_pkg::PRIO_W-1:0]   priority_req_i,
  input  logic [rrts_pkg::STATUS_W-1:0] block_status_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rrts_pkg::CODE_W-1:0]   result_code_o,
  output logic [rrts_pkg::ID_W-1:0]     current_id_o,
  output logic [rrts_pkg::ID_W-1:0]     next_id_o,
  output logic                          switched_o,
  output logic [rrts_pkg::ID_W-1:0]     previous_id_o,
  output logic [rrts_pkg::PRIO_W-1:0]   slice_ticks_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_EXEC      = 4'd1;
  localparam logic [3:0] S_SCHED_RD  = 4'd2;
  localparam logic [3:0] S_SCHED     = 4'd3;
  localparam logic [3:0] S_TAIL      = 4'd4;
  localparam logic [3:0] S_PICK      = 4'd5;
  localparam logic [3:0] S_SWITCH    = 4'd6;
  localparam logic [3:0] S_UNBLK     = 4'd7;
  localparam logic [3:0] S_PUSH_HEAD = 4'd8;
  localparam logic [3:0] S_RD_TICKS  = 4'd9;
  localparam logic [3:0] S_OUT       = 4'd10;

  logic [3:0]                    state_q, state_d;
  logic [rrts_pkg::REQ_W-1:0]    req_q, req_d;
  logic [rrts_pkg::ID_W-1:0]     id_q, id_d;
  logic [rrts_pkg::PRIO_W-1:0]   prio_q, prio_d;
  logic [rrts_pkg::STATUS_W-1:0] bst_q, bst_d;
  rrts_pkg::slot_t               prev_q, prev_d;
  rrts_pkg::slot_t               running_q, running_d;
  rrts_pkg::slot_t               chosen_q, chosen_d;
  logic [rrts_pkg::CODE_W-1:0]   code_q, code_d;
  logic                          sw_q, sw_d;
  logic                          out_valid_q, out_valid_d;
  logic                          out_load;

  logic [rrts_pkg::CODE_W-1:0]   res_code_q;
  rrts_pkg::slot_t               res_cur_q, res_next_q, res_prev_q;
  logic                          res_sw_q;
  logic [rrts_pkg::PRIO_W-1:0]   res_ticks_q;

  rrts_pkg::q_cmd_t               q_cmd;
  rrts_pkg::q_stat_t              q_stat;
  rrts_pkg::slot_wr_t             slot_wr;
  rrts_pkg::slot_rd_t             slot_rd;
  rrts_pkg::slot_data_t           slot_data;
  logic [rrts_pkg::NUM_SLOTS-1:0] slot_valid;

  rrts_pkg::slot_t slot_idx;
  logic            in_range;
  logic            id_ok;
  logic [3:0]      after_sched;

  assign slot_idx    = rrts_pkg::SLOT_W'(id_q);
  assign in_range    = int'(id_q) < rrts_pkg::NUM_SLOTS;
  assign id_ok       = in_range && slot_valid[slot_idx];
  assign after_sched = (req_q == rrts_pkg::REQ_BLOCK) ? S_SWITCH : S_RD_TICKS;
  assign in_stall_o  = (state_q != S_IDLE);

  rrts_slot_table u_slots (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (slot_wr),
    .rd_i      (slot_rd),
    .rd_data_o (slot_data),
    .valid_o   (slot_valid)
  );

  rrts_ready_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (q_cmd),
    .stat_o (q_stat)
  );

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    id_d        = id_q;
    prio_d      = prio_q;
    bst_d       = bst_q;
    prev_d      = prev_q;
    running_d   = running_q;
    chosen_d    = chosen_q;
    code_d      = code_q;
    sw_d        = sw_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_load    = 1'b0;
    q_cmd.op    = rrts_pkg::Q_NONE;
    q_cmd.id    = running_q;
    slot_wr     = '0;
    slot_rd     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = req_type_i;
          id_d    = task_id_i;
          prio_d  = priority_req_i;
          bst_d   = block_status_i;
          prev_d  = running_q;
          code_d  = rrts_pkg::RES_OK;
          sw_d    = 1'b0;
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        unique case (req_q)
          rrts_pkg::REQ_CREATE: begin
            if (!in_range || slot_valid[slot_idx]) begin
              code_d  = rrts_pkg::RES_SLOT;
              state_d = S_RD_TICKS;
            end else begin
              slot_wr.addr    = slot_idx;
              slot_wr.val_set = 1'b1;
              slot_wr.st_we   = 1'b1;
              slot_wr.status  = rrts_pkg::ST_READY;
              slot_wr.pr_we   = 1'b1;
              slot_wr.prio    = prio_q;
              slot_wr.tk_we   = 1'b1;
              slot_wr.ticks   = prio_q;
              q_cmd.op        = rrts_pkg::Q_REMOVE;
              q_cmd.id        = slot_idx;
              state_d         = S_PUSH_HEAD;
            end
          end
          rrts_pkg::REQ_CANCEL: begin
            state_d = S_RD_TICKS;
            if (!id_ok) begin
              code_d = rrts_pkg::RES_SLOT;
            end else if (slot_idx == running_q) begin
              code_d = rrts_pkg::RES_RUNNING;
            end else begin
              q_cmd.op        = rrts_pkg::Q_REMOVE;
              q_cmd.id        = slot_idx;
              slot_wr.addr    = slot_idx;
              slot_wr.val_clr = 1'b1;
              slot_wr.st_we   = 1'b1;
              slot_wr.pr_we   = 1'b1;
              slot_wr.tk_we   = 1'b1;
              if (chosen_q == slot_idx) begin
                chosen_d = running_q;
              end
            end
          end
          rrts_pkg::REQ_SCHEDULE: begin
            slot_rd.en   = 1'b1;
            slot_rd.addr = running_q;
            state_d      = S_SCHED;
          end
          rrts_pkg::REQ_SWITCH: begin
            state_d = S_SWITCH;
          end
          rrts_pkg::REQ_BLOCK: begin
            slot_wr.addr   = running_q;
            slot_wr.st_we  = 1'b1;
            slot_wr.status = bst_q;
            state_d        = S_SCHED_RD;
          end
          rrts_pkg::REQ_UNBLOCK: begin
            if (!id_ok) begin
              code_d  = rrts_pkg::RES_SLOT;
              state_d = S_RD_TICKS;
            end else begin
              slot_rd.en   = 1'b1;
              slot_rd.addr = slot_idx;
              state_d      = S_UNBLK;
            end
          end
          default: begin
            state_d = S_RD_TICKS;
          end
        endcase
      end

      S_SCHED_RD: begin
        slot_rd.en   = 1'b1;
        slot_rd.addr = running_q;
        state_d      = S_SCHED;
      end

      S_SCHED: begin
        slot_wr.addr = running_q;
        if (slot_data.status == rrts_pkg::ST_RUNNING) begin
          // slice expiry: reload, then rotate to the tail if anyone else waits
          slot_wr.tk_we = 1'b1;
          slot_wr.ticks = slot_data.prio;
          if (q_stat.empty) begin
            state_d = after_sched;
          end else begin
            q_cmd.op       = rrts_pkg::Q_REMOVE;
            slot_wr.st_we  = 1'b1;
            slot_wr.status = rrts_pkg::ST_READY;
            state_d        = S_TAIL;
          end
        end else begin
          q_cmd.op = rrts_pkg::Q_REMOVE;
          state_d  = S_PICK;
        end
      end

      S_TAIL: begin
        if (!q_stat.full) begin
          q_cmd.op = rrts_pkg::Q_PUSH_TAIL;
        end
        state_d = S_PICK;
      end

      S_PICK: begin
        if (!q_stat.empty) begin
          chosen_d       = q_stat.head;
          slot_wr.addr   = q_stat.head;
          slot_wr.st_we  = 1'b1;
          slot_wr.status = rrts_pkg::ST_RUNNING;
        end
        state_d = after_sched;
      end

      S_SWITCH: begin
        q_cmd.id = chosen_q;
        if (running_q != chosen_q) begin
          q_cmd.op  = rrts_pkg::Q_REMOVE;
          running_d = chosen_q;
          sw_d      = 1'b1;
        end
        state_d = S_RD_TICKS;
      end

      S_UNBLK: begin
        q_cmd.id = slot_idx;
        if (slot_data.status == rrts_pkg::ST_READY ||
            slot_data.status == rrts_pkg::ST_RUNNING) begin
          state_d = S_RD_TICKS;
        end else if (q_stat.found) begin
          code_d  = rrts_pkg::RES_QUEUED;
          state_d = S_RD_TICKS;
        end else begin
          state_d = S_PUSH_HEAD;
        end
      end

      S_PUSH_HEAD: begin
        q_cmd.id = slot_idx;
        if (!q_stat.full) begin
          q_cmd.op = rrts_pkg::Q_PUSH_HEAD;
        end
        slot_wr.addr   = slot_idx;
        slot_wr.st_we  = 1'b1;
        slot_wr.status = rrts_pkg::ST_READY;
        state_d        = S_RD_TICKS;
      end

      S_RD_TICKS: begin
        slot_rd.en   = 1'b1;
        slot_rd.addr = running_q;
        state_d      = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= '0;
      id_q        <= '0;
      prio_q      <= '0;
      bst_q       <= '0;
      prev_q      <= '0;
      running_q   <= '0;
      chosen_q    <= '0;
      code_q      <= rrts_pkg::RES_OK;
      sw_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      id_q        <= id_d;
      prio_q      <= prio_d;
      bst_q       <= bst_d;
      prev_q      <= prev_d;
      running_q   <= running_d;
      chosen_q    <= chosen_d;
      code_q      <= code_d;
      sw_q        <= sw_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      res_code_q  <= code_q;
      res_cur_q   <= running_q;
      res_next_q  <= chosen_q;
      res_sw_q    <= sw_q;
      res_prev_q  <= prev_q;
      res_ticks_q <= slot_data.ticks;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_code_o = res_code_q;
  assign current_id_o  = rrts_pkg::ID_W'(res_cur_q);
  assign next_id_o     = rrts_pkg::ID_W'(res_next_q);
  assign switched_o    = res_sw_q;
  assign previous_id_o = rrts_pkg::ID_W'(res_prev_q);
  assign slice_ticks_o = res_ticks_q;

endmodule
